FILE: sv/plac_pkg.sv
// ============================================================================
// plac_pkg
// Shared types, constants and helpers for the Phong light accumulation block.
// ============================================================================
package plac_pkg;

    localparam int NUM_LIGHT_SLOTS = 4;
    localparam int LANE_W          = 16;
    localparam int WORD_W          = 48;
    localparam int CFG_IDX_W       = 3;
    localparam int ONE_Q14         = 16384;

    // register indexes of the config port
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_POS0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_POS3   = 3'd4;

    // iterative divider setup
    localparam int DIV_W        = 64;
    localparam int DIV_Q_W      = 32;
    localparam int DIV_STEP_W   = 5;
    localparam int NORM_Q_STEPS = 15;  // quotient bits 14..0
    localparam int AVG_Q_STEPS  = 20;  // accumulator width

    localparam int ACC_W = 20;

    typedef struct packed {
        logic [WORD_W-1:0]       hit;
        logic [WORD_W-1:0]       nrm;
        logic [WORD_W-1:0]       amb;
        logic [WORD_W-1:0]       dif;
        logic [WORD_W-1:0]       spc;
        logic [2:0][LANE_W:0]    vraw;   // ray dir - hit point, 17b signed
        logic [7:0]              shin;
        logic [NUM_LIGHT_SLOTS-1:0] mask;
        logic [2:0]              cnt;    // enabled lights, 1 if none
    } t_item;

    // max(d,0)/2^14 clamped to 1.0 (Q1.14)
    function automatic logic [14:0] cosine(input logic signed [34:0] d);
        logic [34:0] c;
        begin
            c = 35'(d) >> 14;
            if (d <= 0) return 15'd0;
            else if (c > 35'(ONE_Q14)) return 15'(ONE_Q14);
            else return c[14:0];
        end
    endfunction

endpackage

FILE: sv/plac_sqrt.sv
// ============================================================================
// plac_sqrt
// Bit-pair integer square root, one result bit per cycle.
// ============================================================================
module plac_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_value,
    output logic        o_done,
    output logic [31:0] o_root
);
    import plac_pkg::*;

    logic [63:0] r_x, r_r, r_b;
    logic        r_busy, r_done;
    logic [63:0] w_rb;

    assign w_rb = r_r + r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x    <= i_value;
                r_r    <= '0;
                r_b    <= 64'd1 << 62;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_x >= w_rb) begin
                    r_x <= r_x - w_rb;
                    r_r <= (r_r >> 1) + r_b;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_b <= r_b >> 2;
                if (r_b == 64'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[31:0];

endmodule

FILE: sv/plac_div.sv
// ============================================================================
// plac_div
// Restoring divider, one quotient bit per cycle, divisor given pre-aligned.
// ============================================================================
module plac_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [plac_pkg::DIV_W-1:0]       i_dividend,
    input  logic [plac_pkg::DIV_W-1:0]       i_divisor,
    input  logic [plac_pkg::DIV_STEP_W-1:0]  i_steps,
    output logic                             o_done,
    output logic [plac_pkg::DIV_Q_W-1:0]     o_quot
);
    import plac_pkg::*;

    logic [DIV_W-1:0]      r_rem, r_dsh;
    logic [DIV_Q_W-1:0]    r_q;
    logic [DIV_STEP_W-1:0] r_cnt;
    logic                  r_busy, r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= i_dividend;
                r_dsh  <= i_divisor;
                r_q    <= '0;
                r_cnt  <= i_steps;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_rem >= r_dsh) begin
                    r_rem <= r_rem - r_dsh;
                    r_q   <= {r_q[DIV_Q_W-2:0], 1'b1};
                end else begin
                    r_q   <= {r_q[DIV_Q_W-2:0], 1'b0};
                end
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

FILE: sv/plac_front.sv
// ============================================================================
// plac_front
// Takes hit beats, forms the view vector and light count, queues the item.
// ============================================================================
module plac_front #(
    parameter int MAX_LIGHTS = plac_pkg::NUM_LIGHT_SLOTS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic [plac_pkg::WORD_W-1:0]           i_hit_point,
    input  logic [plac_pkg::WORD_W-1:0]           i_surface_normal,
    input  logic [plac_pkg::WORD_W-1:0]           i_ray_direction,
    input  logic [plac_pkg::WORD_W-1:0]           i_ambient_rgb,
    input  logic [plac_pkg::WORD_W-1:0]           i_diffuse_rgb,
    input  logic [plac_pkg::WORD_W-1:0]           i_specular_rgb,
    input  logic [7:0]                            i_shininess,
    input  logic [plac_pkg::NUM_LIGHT_SLOTS-1:0]  i_light_enable,
    input  logic                                  i_pop,
    output logic                                  o_busy,
    output logic                                  o_empty,
    output plac_pkg::t_item                       o_item
);
    import plac_pkg::*;

    localparam logic [NUM_LIGHT_SLOTS-1:0] LightMask =
        NUM_LIGHT_SLOTS'((1 << MAX_LIGHTS) - 1);

    t_item       w_item;
    t_item       r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        w_push;
    logic [NUM_LIGHT_SLOTS-1:0] w_mask;
    logic [2:0]  w_num;

    always_comb begin
        w_mask = i_light_enable & LightMask;
        w_num  = 3'($countones(w_mask));
        w_item.hit  = i_hit_point;
        w_item.nrm  = i_surface_normal;
        w_item.amb  = i_ambient_rgb;
        w_item.dif  = i_diffuse_rgb;
        w_item.spc  = i_specular_rgb;
        w_item.shin = i_shininess;
        w_item.mask = w_mask;
        w_item.cnt  = (w_num == 3'd0) ? 3'd1 : w_num;
        for (int i = 0; i < 3; i++) begin
            w_item.vraw[i] =
                {i_ray_direction[16*i+15], i_ray_direction[16*i +: 16]} -
                {i_hit_point[16*i+15], i_hit_point[16*i +: 16]};
        end
    end

    assign o_busy  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign w_push  = i_start && !o_busy;
    assign o_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_q[r_wp] <= w_item;
                r_wp      <= ~r_wp;
            end
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_pop);
        end
    end

endmodule

FILE: sv/plac_back.sv
// ============================================================================
// plac_back
// Shading engine: per-light normalize, dots, reflect, power, accumulate, average.
// ============================================================================
module plac_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_empty,
    input  plac_pkg::t_item             i_item,
    input  logic [plac_pkg::WORD_W-1:0] i_light_pos [plac_pkg::NUM_LIGHT_SLOTS],
    output logic                        o_pop,
    output logic                        o_valid,
    output logic [plac_pkg::WORD_W-1:0] o_shaded_rgb
);
    import plac_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_NSQ, S_NSQRT_GO, S_NSQRT_WAIT, S_NDIV_GO, S_NDIV_WAIT, S_NRET,
        S_LSEL, S_DOTNL, S_REFL, S_DOTVR, S_POWI, S_POW, S_ACC,
        S_FDIV_GO, S_FDIV_WAIT
    } t_state;

    typedef enum logic [1:0] { RET_V, RET_L, RET_R } t_ret;

    t_state r_state;
    t_ret   r_ret;
    t_item  r_it;

    logic signed [23:0] r_vin  [3];
    logic signed [15:0] r_nout [3];
    logic signed [15:0] r_v [3], r_l [3], r_r [3];
    logic [45:0]        r_s;
    logic [31:0]        r_len;
    logic [1:0]         r_i, r_k;
    logic [2:0]         r_j;
    logic signed [34:0] r_d;
    logic [14:0]        r_cnl, r_cvr, r_pw;
    logic [7:0]         r_e;
    logic [ACC_W-1:0]   r_acc [3];
    logic               r_valid;
    logic [WORD_W-1:0]  r_res;

    logic               r_sq_go, r_dv_go;
    logic [63:0]        r_sq_in;
    logic [DIV_W-1:0]   r_dv_a, r_dv_b;
    logic [DIV_STEP_W-1:0] r_dv_n;
    logic               w_sq_done, w_dv_done;
    logic [31:0]        w_root;
    logic [DIV_Q_W-1:0] w_quot;

    // normalize divide step
    logic [23:0]        w_mag;
    logic [63:0]        w_dvd;
    logic               w_clamp;
    logic [14:0]        w_qn;
    // lane helpers
    logic signed [15:0] w_nrm_i, w_hit_i;
    logic signed [15:0] w_pos_i;
    logic signed [51:0] w_refl;
    logic [1:0]         w_li;
    logic [15:0]        w_col;
    logic [14:0]        w_fac;
    logic [30:0]        w_term;

    plac_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sq_go),
        .i_value (r_sq_in),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    plac_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_dv_go),
        .i_dividend (r_dv_a),
        .i_divisor  (r_dv_b),
        .i_steps    (r_dv_n),
        .o_done     (w_dv_done),
        .o_quot     (w_quot)
    );

    always_comb begin
        w_mag   = r_vin[r_i][23] ? 24'(-r_vin[r_i]) : 24'(r_vin[r_i]);
        w_dvd   = 64'(w_mag) << 22;
        w_clamp = (w_dvd >= (64'(r_len) << 15));
        w_qn    = (w_quot > DIV_Q_W'(ONE_Q14)) ? 15'(ONE_Q14) : w_quot[14:0];
        w_nrm_i = signed'(r_it.nrm[16*r_i +: 16]);
        w_hit_i = signed'(r_it.hit[16*r_i +: 16]);
        w_pos_i = signed'(i_light_pos[r_k][16*r_i +: 16]);
        w_refl  = (36'(r_d) <<< 1) * 52'(w_nrm_i);
        w_li    = (r_j < 3'd3) ? r_j[1:0] : 2'(r_j - 3'd3);
        w_col   = (r_j < 3'd3) ? r_it.dif[16*w_li +: 16] : r_it.spc[16*w_li +: 16];
        w_fac   = (r_j < 3'd3) ? r_cnl : r_pw;
        w_term  = 31'(w_col) * 31'(w_fac);
    end

    assign o_pop        = (r_state == S_IDLE) && !i_empty;
    assign o_valid      = r_valid;
    assign o_shaded_rgb = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_sq_go <= 1'b0;
            r_dv_go <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            r_sq_go <= 1'b0;
            r_dv_go <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_it <= i_item;
                        for (int c = 0; c < 3; c++) begin
                            r_acc[c] <= ACC_W'(i_item.amb[16*c +: 16]);
                            r_vin[c] <= 24'(signed'(i_item.vraw[c]));
                        end
                        r_s     <= '0;
                        r_i     <= 2'd0;
                        r_ret   <= RET_V;
                        r_state <= S_NSQ;
                    end
                end
                S_NSQ: begin
                    r_s <= r_s + 46'(r_vin[r_i] * r_vin[r_i]);
                    if (r_i == 2'd2) r_state <= S_NSQRT_GO;
                    else r_i <= r_i + 1'b1;
                end
                S_NSQRT_GO: begin
                    if (r_s == '0) begin
                        for (int c = 0; c < 3; c++) r_nout[c] <= '0;
                        r_state <= S_NRET;
                    end else begin
                        r_sq_in <= {2'b00, r_s, 16'h0000};
                        r_sq_go <= 1'b1;
                        r_state <= S_NSQRT_WAIT;
                    end
                end
                S_NSQRT_WAIT: begin
                    if (w_sq_done) begin
                        r_len   <= w_root;
                        r_i     <= 2'd0;
                        r_state <= S_NDIV_GO;
                    end
                end
                S_NDIV_GO: begin
                    if (w_clamp) begin
                        r_nout[r_i] <= r_vin[r_i][23] ? -16'(ONE_Q14) : 16'(ONE_Q14);
                        if (r_i == 2'd2) r_state <= S_NRET;
                        else r_i <= r_i + 1'b1;
                    end else begin
                        r_dv_a  <= w_dvd;
                        r_dv_b  <= 64'(r_len) << 14;
                        r_dv_n  <= DIV_STEP_W'(NORM_Q_STEPS);
                        r_dv_go <= 1'b1;
                        r_state <= S_NDIV_WAIT;
                    end
                end
                S_NDIV_WAIT: begin
                    if (w_dv_done) begin
                        r_nout[r_i] <= r_vin[r_i][23] ? -16'(w_qn) : 16'(w_qn);
                        if (r_i == 2'd2) r_state <= S_NRET;
                        else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_NDIV_GO;
                        end
                    end
                end
                S_NRET: begin
                    r_i <= 2'd0;
                    r_d <= '0;
                    unique case (r_ret)
                        RET_V: begin
                            r_v     <= r_nout;
                            r_k     <= 2'd0;
                            r_state <= S_LSEL;
                        end
                        RET_L: begin
                            r_l     <= r_nout;
                            r_state <= S_DOTNL;
                        end
                        RET_R: begin
                            r_r     <= r_nout;
                            r_state <= S_DOTVR;
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_LSEL: begin
                    if (r_it.mask[r_k]) begin
                        // build light - point one lane a cycle
                        r_vin[r_i] <= 24'(w_pos_i) - 24'(w_hit_i);
                        if (r_i == 2'd2) begin
                            r_i     <= 2'd0;
                            r_s     <= '0;
                            r_ret   <= RET_L;
                            r_state <= S_NSQ;
                        end else r_i <= r_i + 1'b1;
                    end else if (r_k == 2'd3) begin
                        r_i     <= 2'd0;
                        r_state <= S_FDIV_GO;
                    end else r_k <= r_k + 1'b1;
                end
                S_DOTNL: begin
                    r_d <= r_d + 35'(w_nrm_i * r_l[r_i]);
                    if (r_i == 2'd2) begin
                        r_i     <= 2'd0;
                        r_state <= S_REFL;
                    end else r_i <= r_i + 1'b1;
                end
                S_REFL: begin
                    r_cnl      <= cosine(r_d);
                    r_vin[r_i] <= 24'(r_l[r_i]) - 24'(w_refl >>> 28);
                    if (r_i == 2'd2) begin
                        r_i     <= 2'd0;
                        r_s     <= '0;
                        r_ret   <= RET_R;
                        r_state <= S_NSQ;
                    end else r_i <= r_i + 1'b1;
                end
                S_DOTVR: begin
                    r_d <= r_d + 35'(r_v[r_i] * r_r[r_i]);
                    if (r_i == 2'd2) r_state <= S_POWI;
                    else r_i <= r_i + 1'b1;
                end
                S_POWI: begin
                    r_cvr   <= cosine(r_d);
                    r_pw    <= 15'(ONE_Q14);
                    r_e     <= '0;
                    r_state <= S_POW;
                end
                S_POW: begin
                    // 0 and 1.0 are fixed points of the power step
                    if (r_e == r_it.shin || r_pw == '0 || r_cvr == 15'(ONE_Q14)) begin
                        r_j     <= 3'd0;
                        r_state <= S_ACC;
                    end else begin
                        r_pw <= 15'((30'(r_pw) * 30'(r_cvr)) >> 14);
                        r_e  <= r_e + 1'b1;
                    end
                end
                S_ACC: begin
                    r_acc[w_li] <= r_acc[w_li] + ACC_W'(w_term >> 14);
                    if (r_j == 3'd5) begin
                        if (r_k == 2'd3) begin
                            r_i     <= 2'd0;
                            r_state <= S_FDIV_GO;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_i     <= 2'd0;
                            r_state <= S_LSEL;
                        end
                    end else r_j <= r_j + 1'b1;
                end
                S_FDIV_GO: begin
                    r_dv_a  <= DIV_W'(r_acc[r_i]);
                    r_dv_b  <= DIV_W'(r_it.cnt) << (AVG_Q_STEPS - 1);
                    r_dv_n  <= DIV_STEP_W'(AVG_Q_STEPS);
                    r_dv_go <= 1'b1;
                    r_state <= S_FDIV_WAIT;
                end
                S_FDIV_WAIT: begin
                    if (w_dv_done) begin
                        r_res[16*r_i +: 16] <=
                            (w_quot > DIV_Q_W'(16'hFFFF)) ? 16'hFFFF : w_quot[15:0];
                        if (r_i == 2'd2) begin
                            r_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_FDIV_GO;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: sv/phong_light_accumulation.sv
// ============================================================================
// phong_light_accumulation
// Phong shading of one ray hit over up to four point lights, fixed point.
// ============================================================================
//  channel   direction  handshake                 payload
//  hit       in         i_start, o_busy           i_hit_point .. i_shininess
//  result    out        o_valid (strobe)          o_shaded_rgb
//  config    in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
//  A hit beat is taken when i_start is high and o_busy low; a two-entry queue
//  lets two more hits wait while the engine works on the current one.
//  Work per hit: a view normalize (sums of squares, a 32-step square root,
//  up to three 15-step divides), then per enabled light two such normalizes
//  plus dots, reflect, a power loop over the shininess and accumulate, a skip
//  for each disabled light, and a final average of three divides. The
//  normalizes share one sqrt unit; all divides share one divider unit.
//  Reset (synchronous, active low) empties the queue, idles the engine, sets
//  light_enable to 1 and all light positions to 0. No clearing pass.
//  o_valid is a one-cycle strobe; the receiver cannot stall it.
// ============================================================================
module phong_light_accumulation #(
    parameter int MAX_LIGHTS = plac_pkg::NUM_LIGHT_SLOTS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic [plac_pkg::WORD_W-1:0]       i_hit_point,
    input  logic [plac_pkg::WORD_W-1:0]       i_surface_normal,
    input  logic [plac_pkg::WORD_W-1:0]       i_ray_direction,
    input  logic [plac_pkg::WORD_W-1:0]       i_ambient_rgb,
    input  logic [plac_pkg::WORD_W-1:0]       i_diffuse_rgb,
    input  logic [plac_pkg::WORD_W-1:0]       i_specular_rgb,
    input  logic [7:0]                        i_shininess,
    output logic                              o_valid,
    output logic [plac_pkg::WORD_W-1:0]       o_shaded_rgb,
    input  logic                              i_cfg_we,
    input  logic [plac_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [plac_pkg::WORD_W-1:0]       i_cfg_data
);
    import plac_pkg::*;

    // config registers
    logic [NUM_LIGHT_SLOTS-1:0] r_light_enable;
    logic [WORD_W-1:0]          r_light_pos [NUM_LIGHT_SLOTS];

    logic  w_pop, w_empty;
    t_item w_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_enable <= NUM_LIGHT_SLOTS'(1);
            for (int k = 0; k < NUM_LIGHT_SLOTS; k++) r_light_pos[k] <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_LIGHT_ENABLE) begin
                r_light_enable <= i_cfg_data[NUM_LIGHT_SLOTS-1:0];
            end else if (i_cfg_idx <= CFG_LIGHT_POS3) begin
                // indexes past the last light are dropped
                r_light_pos[2'(i_cfg_idx - CFG_LIGHT_POS0)] <= i_cfg_data;
            end
        end
    end

    // front: accept, view vector, light count, queue
    plac_front #(
        .MAX_LIGHTS (MAX_LIGHTS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .i_hit_point      (i_hit_point),
        .i_surface_normal (i_surface_normal),
        .i_ray_direction  (i_ray_direction),
        .i_ambient_rgb    (i_ambient_rgb),
        .i_diffuse_rgb    (i_diffuse_rgb),
        .i_specular_rgb   (i_specular_rgb),
        .i_shininess      (i_shininess),
        .i_light_enable   (r_light_enable),
        .i_pop            (w_pop),
        .o_busy           (o_busy),
        .o_empty          (w_empty),
        .o_item           (w_item)
    );

    // back: per-light shading and final average
    plac_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (w_empty),
        .i_item       (w_item),
        .i_light_pos  (r_light_pos),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .o_shaded_rgb (o_shaded_rgb)
    );

endmodule

FILE: sv/plac_checker.sv
// ============================================================================
// plac_checker
// Port-level checks on the shading block, bound to the top level.
// ============================================================================
module plac_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_valid
);
    // result strobes never come back to back: every hit takes many cycles
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("two result beats in a row");

    // queue fills only on an accepted hit
    a_busy_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_busy) |-> $past(i_start))
        else $error("busy rose without an incoming hit");

    // reset leaves the block empty and quiet
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_busy))
        else $error("busy or valid after reset");

endmodule

bind phong_light_accumulation plac_checker u_plac_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .o_valid (o_valid)
);

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for phong_light_accumulation: hit beats are queued by
// an initial block and fed through start/busy by a clocked driver; a clocked
// monitor compares every result strobe against the shade predicted at the
// edge the beat was taken. Light registers change only between drained phases.
// ============================================================================
module tb_top;

    import plac_pkg::*;

    localparam int CLK_LIMIT = 3000000;   // cycles before the run is abandoned
    localparam int TAIL_WAIT = 2000;      // roughly one full-shininess hit
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_FIRST = CFG_IDX_W'(CFG_LIGHT_POS3 + 1);

    typedef struct {
        logic [WORD_W-1:0] hit;
        logic [WORD_W-1:0] nrm;
        logic [WORD_W-1:0] dir;
        logic [WORD_W-1:0] amb;
        logic [WORD_W-1:0] dif;
        logic [WORD_W-1:0] spc;
        logic [7:0]        shin;
    } hit_beat_t;

    // ---- DUT ports, inputs known from time zero ----
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_start = 1'b0;
    logic              o_busy;
    logic [WORD_W-1:0] i_hit_point = '0;
    logic [WORD_W-1:0] i_surface_normal = '0;
    logic [WORD_W-1:0] i_ray_direction = '0;
    logic [WORD_W-1:0] i_ambient_rgb = '0;
    logic [WORD_W-1:0] i_diffuse_rgb = '0;
    logic [WORD_W-1:0] i_specular_rgb = '0;
    logic [7:0]        i_shininess = '0;
    logic              o_valid;
    logic [WORD_W-1:0] o_shaded_rgb;
    logic              i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [WORD_W-1:0] i_cfg_data = '0;

    phong_light_accumulation dut (.*);

    // ---- bench state ----
    hit_beat_t         pending_hits[$];
    logic [WORD_W-1:0] shade_expect[$];
    logic [3:0]        mirror_enable = 4'd1;        // reset values of the block
    logic [WORD_W-1:0] mirror_pos[4] = '{default: '0};
    int                fail_count = 0;
    int                gap_left = 0;
    bit                quiet_gaps = 1'b0;            // phase with no idle cycles
    int                cycle_count = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---- predictor ----
    function automatic longint int_sqrt(input longint x);
        longint r, b;
        begin
            r = 0;
            b = 64'sd1 <<< 62;
            while (b > x) b = b >>> 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >>> 1) + b;
                end else begin
                    r = r >>> 1;
                end
                b = b >>> 2;
            end
            return r;
        end
    endfunction

    // Q1.14 unit vector; a zero vector stays zero
    function automatic void unitize(input longint v[3], output longint u[3]);
        longint s, len, mag, q;
        begin
            s = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
            if (s == 0) begin
                u = '{0, 0, 0};
                return;
            end
            len = int_sqrt(s <<< 16);
            for (int i = 0; i < 3; i++) begin
                mag = (v[i] < 0) ? -v[i] : v[i];
                q = (mag <<< 22) / len;
                if (q > ONE_Q14) q = ONE_Q14;
                u[i] = (v[i] < 0) ? -q : q;
            end
        end
    endfunction

    function automatic longint clamp_cos(input longint d);
        longint c;
        begin
            if (d <= 0) return 0;
            c = d >>> 14;
            return (c > ONE_Q14) ? ONE_Q14 : c;
        end
    endfunction

    function automatic longint lane_s(input logic [WORD_W-1:0] w, input int i);
        return longint'($signed(w[16*i +: 16]));
    endfunction

    function automatic longint lane_u(input logic [WORD_W-1:0] w, input int i);
        return longint'({48'd0, w[16*i +: 16]});
    endfunction

    function automatic logic [WORD_W-1:0] predict_shade(input hit_beat_t b);
        longint p[3], n[3], vraw[3], v[3], acc[3];
        longint lraw[3], l[3], rraw[3], r[3];
        longint d, cnl, cvr, pw, lights, c;
        logic [WORD_W-1:0] res;
        begin
            lights = 0;
            res = '0;
            for (int i = 0; i < 3; i++) begin
                p[i] = lane_s(b.hit, i);
                n[i] = lane_s(b.nrm, i);
                vraw[i] = lane_s(b.dir, i) - p[i];
                acc[i] = lane_u(b.amb, i);
            end
            unitize(vraw, v);
            for (int k = 0; k < NUM_LIGHT_SLOTS; k++) begin
                if (mirror_enable[k]) begin
                    lights++;
                    for (int i = 0; i < 3; i++) lraw[i] = lane_s(mirror_pos[k], i) - p[i];
                    unitize(lraw, l);
                    d = n[0] * l[0] + n[1] * l[1] + n[2] * l[2];
                    cnl = clamp_cos(d);
                    // reflect about N; arithmetic shift floors
                    for (int i = 0; i < 3; i++) rraw[i] = l[i] - ((2 * d * n[i]) >>> 28);
                    unitize(rraw, r);
                    cvr = clamp_cos(v[0] * r[0] + v[1] * r[1] + v[2] * r[2]);
                    pw = ONE_Q14;
                    for (int e = 0; e < b.shin; e++) pw = (pw * cvr) >>> 14;
                    for (int i = 0; i < 3; i++) begin
                        acc[i] += (lane_u(b.dif, i) * cnl) >>> 14;
                        acc[i] += (lane_u(b.spc, i) * pw) >>> 14;
                    end
                end
            end
            if (lights == 0) lights = 1;
            for (int i = 0; i < 3; i++) begin
                c = acc[i] / lights;
                if (c > 16'hFFFF) c = 16'hFFFF;
                res[16*i +: 16] = c[15:0];
            end
            return res;
        end
    endfunction

    // ---- driver: one beat per start/!busy edge ----
    function automatic int pick_gap();
        int r;
        begin
            if (quiet_gaps) return 0;
            r = $urandom_range(0, 99);
            if (r < 55) return 0;
            if (r < 90) return $urandom_range(1, 3);
            return $urandom_range(20, 250);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (!(i_start && o_busy)) begin
            if (i_start) begin
                shade_expect.push_back(predict_shade('{i_hit_point, i_surface_normal,
                    i_ray_direction, i_ambient_rgb, i_diffuse_rgb, i_specular_rgb,
                    i_shininess}));
            end
            if (gap_left > 0) begin
                gap_left--;
                i_start <= 1'b0;
            end else if (pending_hits.size() > 0) begin
                hit_beat_t b;
                b = pending_hits.pop_front();
                i_hit_point      <= b.hit;
                i_surface_normal <= b.nrm;
                i_ray_direction  <= b.dir;
                i_ambient_rgb    <= b.amb;
                i_diffuse_rgb    <= b.dif;
                i_specular_rgb   <= b.spc;
                i_shininess      <= b.shin;
                i_start          <= 1'b1;
                gap_left = pick_gap();
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // ---- monitor: a strobe cannot be held off, check it on the spot ----
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (shade_expect.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual %h",
                         $time, o_shaded_rgb);
                fail_count++;
            end else begin
                logic [WORD_W-1:0] want;
                want = shade_expect.pop_front();
                if (o_shaded_rgb !== want) begin
                    $display("%0t: shaded_rgb mismatch, expected %h, actual %h",
                             $time, want, o_shaded_rgb);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CLK_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---- stimulus helpers ----
    function automatic logic [15:0] rand_q78();
        // mostly within a few units of the origin, sometimes anywhere
        if ($urandom_range(0, 9) < 7) return 16'($urandom_range(0, 16'h1000)) - 16'h0800;
        return 16'($urandom);
    endfunction

    function automatic logic [WORD_W-1:0] rand_vec();
        return {rand_q78(), rand_q78(), rand_q78()};
    endfunction

    function automatic logic [WORD_W-1:0] rand_color();
        logic [WORD_W-1:0] c;
        for (int i = 0; i < 3; i++)
            c[16*i +: 16] = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                         : 16'($urandom_range(0, 16'h2000));
        return c;
    endfunction

    function automatic logic [WORD_W-1:0] rand_normal();
        logic [WORD_W-1:0] w;
        int r;
        r = $urandom_range(0, 9);
        w = '0;
        if (r < 5) begin
            // axis-aligned unit normal
            w[16*$urandom_range(0, 2) +: 16] = $urandom_range(0, 1) ? 16'h4000 : 16'hC000;
        end else if (r < 8) begin
            for (int i = 0; i < 3; i++) w[16*i +: 16] = 16'($urandom_range(0, 16'h4000)) - 16'h2000;
        end else begin
            w = {16'($urandom), 16'($urandom), 16'($urandom)};
        end
        return w;
    endfunction

    function automatic hit_beat_t rand_beat();
        hit_beat_t b;
        int r;
        b.hit = rand_vec();
        b.nrm = rand_normal();
        b.dir = rand_vec();
        b.amb = rand_color();
        b.dif = rand_color();
        b.spc = rand_color();
        r = $urandom_range(0, 99);
        b.shin = (r < 85) ? 8'($urandom_range(0, 32)) : (r < 92) ? 8'd255 : 8'($urandom);
        if ($urandom_range(0, 19) == 0) b.dir = b.hit;    // degenerate view vector
        return b;
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        if (idx == CFG_LIGHT_ENABLE) mirror_enable = val[3:0];
        else if (idx <= CFG_LIGHT_POS3) mirror_pos[2'(idx - CFG_LIGHT_POS0)] = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_lights(input logic [WORD_W-1:0] en, input logic [WORD_W-1:0] p0,
                               input logic [WORD_W-1:0] p1, input logic [WORD_W-1:0] p2,
                               input logic [WORD_W-1:0] p3);
        cfg_write(CFG_LIGHT_ENABLE, en);
        cfg_write(CFG_LIGHT_POS0,     p0);
        cfg_write(CFG_IDX_W'(CFG_LIGHT_POS0 + 1), p1);
        cfg_write(CFG_IDX_W'(CFG_LIGHT_POS0 + 2), p2);
        cfg_write(CFG_LIGHT_POS3,     p3);
        // indexes past the list must not disturb anything
        for (int j = CFG_UNUSED_FIRST; j < (1 << CFG_IDX_W); j++)
            cfg_write(CFG_IDX_W'(j), {16'($urandom), 16'($urandom), 16'($urandom)});
    endtask

    // wait until the block is empty; checked off the clock edge
    task automatic drain();
        do @(negedge i_clk);
        while (pending_hits.size() != 0 || i_start || shade_expect.size() != 0);
    endtask

    task automatic push_beat(input logic [WORD_W-1:0] hit, input logic [WORD_W-1:0] nrm,
                             input logic [WORD_W-1:0] dir, input logic [WORD_W-1:0] col,
                             input logic [7:0] shin);
        pending_hits.push_back('{hit, nrm, dir, col, col, col, shin});
    endtask

    // ---- sequence ----
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: light 0 only, at the origin
        push_beat('0, 48'h0000_0000_4000, 48'h0000_0000_0100, 48'h1000_1000_1000, 8'd0);
        push_beat(48'h0100_0000_0000, 48'h4000_0000_0000, 48'h0000_0000_0000,
                  48'hFFFF_FFFF_FFFF, 8'd1);
        push_beat('0, '0, '0, 48'h0123_4567_89AB, 8'd3);          // hit on the light
        drain();

        // all four lights, lanes at the extremes
        quiet_gaps = 1'b1;
        load_lights(48'hFFFF_FFFF_FFFF, 48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000,
                    48'h7FFF_8000_0000, 48'h0100_0000_0000);
        push_beat(48'h8000_8000_8000, 48'h4000_0000_0000, 48'h7FFF_7FFF_7FFF,
                  48'hFFFF_FFFF_FFFF, 8'd255);                     // saturation
        push_beat(48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, 48'h8000_8000_8000,
                  48'hFFFF_FFFF_FFFF, 8'd128);                     // non-unit normal
        push_beat('0, 48'h7FFF_7FFF_7FFF, 48'h0000_0000_0000, 48'h0000_0000_0000, 8'd0);
        push_beat('0, 48'hC000_0000_0000, 48'h0200_0000_0000, 48'h2000_1000_0800, 8'd7);
        push_beat(48'h0100_0000_0000, '0, 48'h0100_0000_0000, 48'h0800_0800_0800, 8'd64);
        push_beat(48'h0000_0000_0080, 48'h0000_4000_0000, 48'h0000_0400_0080,
                  48'h5555_AAAA_5555, 8'd2);
        push_beat(48'h0000_0000_0080, 48'h0000_4000_0000, 48'h0000_0400_0080,
                  48'hAAAA_5555_AAAA, 8'd32);
        drain();
        quiet_gaps = 1'b0;

        // no light enabled (high data bits masked away): ambient passes through
        load_lights(48'hFFFF_FFFF_FFF0, 48'h1234_5678_9ABC, 48'hFEDC_BA98_7654,
                    48'h0F0F_F0F0_0F0F, 48'hF0F0_0F0F_F0F0);
        push_beat(48'h0100_0100_0100, 48'h0000_0000_4000, 48'h0200_0000_0000,
                  48'hFFFF_0000_8001, 8'd5);
        push_beat('0, '0, '0, 48'h0001_7FFF_FFFE, 8'd255);
        drain();

        // single lights, one at a time
        for (int k = 0; k < NUM_LIGHT_SLOTS; k++) begin
            load_lights(48'(1 << k), rand_vec(), rand_vec(), rand_vec(), rand_vec());
            push_beat('0, 48'h0000_4000_0000, 48'h0000_0400_0000, 48'h3000_2000_1000, 8'd4);
            push_beat(48'h0080_FF80_0040, rand_normal(), rand_vec(), 48'h0FFF_0FFF_0FFF,
                      8'd16);
            drain();
        end

        // random phases, each with its own light setup
        for (int ph = 0; ph < 8; ph++) begin
            quiet_gaps = ($urandom_range(0, 3) == 0);
            if (ph == 0)
                load_lights(48'hF, 48'h7FFF_8000_7FFF, 48'h8000_7FFF_8000, '0,
                            48'hFFFF_FFFF_FFFF);
            else if (ph == 1)
                load_lights(48'h0, rand_vec(), rand_vec(), rand_vec(), rand_vec());
            else
                load_lights(48'($urandom_range(0, 15)), rand_vec(), rand_vec(),
                            rand_vec(), rand_vec());
            for (int j = 0; j < 47; j++) pending_hits.push_back(rand_beat());
            drain();
        end

        repeat (TAIL_WAIT) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
